@@ hdl/adaptive_tick_timer_wheel_unit_assert.svh @@
// Assertion helpers used by the timer wheel core.
`ifndef ADAPTIVE_TICK_TIMER_WHEEL_UNIT_ASSERT_SVH
`define ADAPTIVE_TICK_TIMER_WHEEL_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ATW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ATW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/atw_pkg.sv @@
`default_nettype none

package atw_pkg;

    localparam int MAX_SLOT_BITS_DEF = 8;

    localparam int SLOT_INDEX_W = 8;
    localparam int MS_W = 32;
    localparam int LOG2_W = 4;
    localparam int INTERVAL_W = 14;
    localparam int RELOAD_W = 15;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [MS_W-1:0] SLOT_LENGTH_RESET = 32'd1;
    localparam logic [LOG2_W-1:0] SLOT_COUNT_LOG2_RESET = 4'd3;

    localparam logic [INTERVAL_W-1:0] INTERVAL_10S = 14'd10000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_1S = 14'd1000;
    localparam logic [INTERVAL_W-1:0] INTERVAL_100MS = 14'd100;
    localparam logic [INTERVAL_W-1:0] INTERVAL_10MS = 14'd10;

    typedef enum logic [1:0] {
        OP_UPDATE = 2'd0,
        OP_EXPIRY = 2'd1,
        OP_ADD    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        PH_INIT    = 2'd0,
        PH_WAITING = 2'd1,
        PH_EXPIRED = 2'd2
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SLOT_LENGTH     = 2'd0,
        CFG_SLOT_COUNT_LOG2 = 2'd1,
        CFG_WHEEL_SHUT      = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [MS_W-1:0]   slot_length_ms;
        logic [LOG2_W-1:0] slot_count_log2;
        logic              wheel_shut;
    } cfg_t;

    typedef struct packed {
        logic [1:0]      operation;
        logic [MS_W-1:0] add_ms;
    } item_t;

    typedef struct packed {
        logic [SLOT_INDEX_W-1:0] slot_index;
        logic [MS_W-1:0]         remaining_ms;
        logic                    init_request;
        logic                    reload_valid;
        logic [INTERVAL_W-1:0]   tick_span_ms;
        logic [RELOAD_W-1:0]     period_reload;
        logic [1:0]              phase_out;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/atw_item_if.sv @@
`default_nettype none

interface atw_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] add_ms;

    modport source (output valid, output operation, output add_ms, input ready);
    modport sink (input valid, input operation, input add_ms, output ready);
endinterface

`default_nettype wire

@@ hdl/atw_result_if.sv @@
`default_nettype none

interface atw_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slot_index;
    logic [31:0] remaining_ms;
    logic        init_request;
    logic        reload_valid;
    logic [13:0] tick_span_ms;
    logic [14:0] period_reload;
    logic [1:0]  phase_out;

    modport source (
        output valid, output slot_index, output remaining_ms, output init_request,
        output reload_valid, output tick_span_ms, output period_reload, output phase_out,
        input ready
    );
    modport sink (
        input valid, input slot_index, input remaining_ms, input init_request,
        input reload_valid, input tick_span_ms, input period_reload, input phase_out,
        output ready
    );
endinterface

`default_nettype wire

@@ hdl/atw_cfg_if.sv @@
`default_nettype none

interface atw_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/adaptive_tick_timer_wheel_unit.sv @@
// An input item is registered in the input stage and then in the result register that drives the result.
// Throughput: one item per cycle while the result side is ready; the input and result registers each hold one item.
// The wheel state updates at the edge that loads the result, so the next item sees it at once.
// Reset clears the phase to init, the slot remainder, position and last interval to zero,
// and loads the registers with slot length 1, slot count log2 3 and the wheel open.
`default_nettype none

module adaptive_tick_timer_wheel_unit #(
    parameter int MAX_SLOT_BITS = atw_pkg::MAX_SLOT_BITS_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    atw_item_if.sink     item,
    atw_result_if.source result,
    atw_cfg_if.sink      cfg
);
    import atw_pkg::*;

    cfg_t  cfg_words;
    item_t stage_item;
    logic  stage_valid;
    logic  take;

    atw_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_words)
    );

    atw_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (item),
        .take        (take),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    atw_core #(
        .MAX_SLOT_BITS (MAX_SLOT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .cfg_in      (cfg_words),
        .take        (take),
        .result      (result)
    );

endmodule

`default_nettype wire

@@ hdl/atw_cfg_regs.sv @@
`default_nettype none

module atw_cfg_regs (
    input  wire logic  clk,
    input  wire logic  rst_n,
    atw_cfg_if.sink    cfg,
    output atw_pkg::cfg_t cfg_out
);
    import atw_pkg::*;

    logic [MS_W-1:0]   slot_length_reg;
    logic [LOG2_W-1:0] slot_count_log2_reg;
    logic              wheel_shut_reg;
    logic              write_en;

    assign cfg.ready = 1'b1;
    assign write_en = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_length_reg     <= SLOT_LENGTH_RESET;
            slot_count_log2_reg <= SLOT_COUNT_LOG2_RESET;
            wheel_shut_reg      <= 1'b0;
        end
        else if (write_en)
        begin
            case (cfg_index_t'(cfg.index))
                CFG_SLOT_LENGTH:     slot_length_reg <= cfg.data;
                CFG_SLOT_COUNT_LOG2: slot_count_log2_reg <= cfg.data[LOG2_W-1:0];
                CFG_WHEEL_SHUT:      wheel_shut_reg <= cfg.data[0];
                default:             ;
            endcase
        end
    end

    assign cfg_out.slot_length_ms  = slot_length_reg;
    assign cfg_out.slot_count_log2 = slot_count_log2_reg;
    assign cfg_out.wheel_shut      = wheel_shut_reg;

endmodule

`default_nettype wire

@@ hdl/atw_in_stage.sv @@
`default_nettype none

module atw_in_stage (
    input  wire logic clk,
    input  wire logic rst_n,
    atw_item_if.sink  item,
    input  wire logic take,
    output logic      stage_valid,
    output atw_pkg::item_t stage_item
);
    import atw_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign item.ready = !valid_reg || take;
    assign load = item.valid && item.ready;
    assign valid_next = load || (valid_reg && !take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.operation <= item.operation;
            item_reg.add_ms    <= item.add_ms;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item = item_reg;

endmodule

`default_nettype wire

@@ hdl/atw_core.sv @@
`default_nettype none
`include "adaptive_tick_timer_wheel_unit_assert.svh"

module atw_core #(
    parameter int MAX_SLOT_BITS = atw_pkg::MAX_SLOT_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic stage_valid,
    input  wire atw_pkg::item_t stage_item,
    input  wire atw_pkg::cfg_t cfg_in,
    output logic      take,
    atw_result_if.source result
);
    import atw_pkg::*;

    localparam int BITS_W = $clog2(MAX_SLOT_BITS + 1);

    phase_t                   phase_reg;
    phase_t                   phase_next;
    logic [MS_W-1:0]          remaining_reg;
    logic [MS_W-1:0]          remaining_next;
    logic [MAX_SLOT_BITS-1:0] position_reg;
    logic [MAX_SLOT_BITS-1:0] position_next;
    logic [INTERVAL_W-1:0]    last_interval_reg;
    logic [INTERVAL_W-1:0]    last_interval_next;
    logic                     res_valid_reg;
    logic                     res_valid_next;
    result_t                  res_reg;
    result_t                  res_next;

    logic                     do_update;
    logic                     from_init;
    logic                     do_add;
    logic [MS_W-1:0]          rem_consumed;
    logic [MS_W-1:0]          rem_refilled;
    logic                     refill;
    logic [INTERVAL_W-1:0]    interval;
    logic [RELOAD_W-1:0]      reload;
    logic [MS_W:0]            add_sum;
    logic [BITS_W-1:0]        eff_bits;
    logic [MAX_SLOT_BITS-1:0] slot_mask;
    logic [MAX_SLOT_BITS-1:0] position_inc;

    assign take = stage_valid && (!res_valid_reg || result.ready);

    assign from_init = (phase_reg == PH_INIT);
    assign do_update = take && (op_t'(stage_item.operation) == OP_UPDATE)
                       && (phase_reg == PH_INIT || phase_reg == PH_EXPIRED);
    assign do_add = take && (op_t'(stage_item.operation) == OP_ADD) && !cfg_in.wheel_shut
                    && (stage_item.add_ms != '0) && (cfg_in.slot_length_ms != '0);

    // The slot index wraps at the configured count, limited to the position width.
    always_comb
    begin
        if ({1'b0, cfg_in.slot_count_log2} > (LOG2_W + 1)'(MAX_SLOT_BITS))
        begin
            eff_bits = BITS_W'(MAX_SLOT_BITS);
        end
        else
        begin
            eff_bits = BITS_W'(cfg_in.slot_count_log2);
        end
        for (int i = 0; i < MAX_SLOT_BITS; i++)
        begin
            slot_mask[i] = (BITS_W'(i) < eff_bits);
        end
    end

    assign position_inc = (position_reg + MAX_SLOT_BITS'(1)) & slot_mask;

    always_comb
    begin
        if (from_init)
        begin
            rem_consumed = remaining_reg;
        end
        else if (remaining_reg >= MS_W'(last_interval_reg))
        begin
            rem_consumed = remaining_reg - MS_W'(last_interval_reg);
        end
        else
        begin
            rem_consumed = '0;
        end
        refill = (rem_consumed == '0);
        rem_refilled = refill ? cfg_in.slot_length_ms : rem_consumed;

        if (rem_refilled >= MS_W'(INTERVAL_10S))
        begin
            interval = INTERVAL_10S;
        end
        else if (rem_refilled >= MS_W'(INTERVAL_1S))
        begin
            interval = INTERVAL_1S;
        end
        else if (rem_refilled >= MS_W'(INTERVAL_100MS))
        begin
            interval = INTERVAL_100MS;
        end
        else if (rem_refilled >= MS_W'(INTERVAL_10MS))
        begin
            interval = INTERVAL_10MS;
        end
        else
        begin
            interval = rem_refilled[INTERVAL_W-1:0];
        end
        reload = (interval == '0) ? '0 : ({interval, 1'b0} - RELOAD_W'(1));
    end

    assign add_sum = {1'b0, remaining_reg} + {1'b0, stage_item.add_ms};

    // Phase transitions.
    always_comb
    begin
        phase_next = phase_reg;
        if (take)
        begin
            case (op_t'(stage_item.operation))
                OP_UPDATE:
                begin
                    if (do_update)
                    begin
                        phase_next = PH_WAITING;
                    end
                end
                OP_EXPIRY: phase_next = PH_EXPIRED;
                default:   phase_next = phase_reg;
            endcase
        end
    end

    // Wheel state and the result word.
    always_comb
    begin
        remaining_next     = remaining_reg;
        position_next      = position_reg;
        last_interval_next = last_interval_reg;
        if (do_update)
        begin
            remaining_next     = rem_refilled;
            last_interval_next = interval;
            if (refill && !from_init)
            begin
                position_next = position_inc;
            end
        end
        else if (do_add)
        begin
            if (add_sum >= {1'b0, cfg_in.slot_length_ms})
            begin
                position_next  = position_inc;
                remaining_next = '0;
            end
            else
            begin
                remaining_next = add_sum[MS_W-1:0];
            end
        end

        res_next.slot_index    = SLOT_INDEX_W'(position_next);
        res_next.remaining_ms  = remaining_next;
        res_next.init_request  = do_update && from_init;
        res_next.reload_valid  = do_update;
        res_next.tick_span_ms  = do_update ? interval : '0;
        res_next.period_reload = do_update ? reload : '0;
        res_next.phase_out     = phase_next;

        res_valid_next = take || (res_valid_reg && !result.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_INIT;
            remaining_reg     <= '0;
            position_reg      <= '0;
            last_interval_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            remaining_reg     <= remaining_next;
            position_reg      <= position_next;
            last_interval_reg <= last_interval_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.slot_index    = res_reg.slot_index;
    assign result.remaining_ms  = res_reg.remaining_ms;
    assign result.init_request  = res_reg.init_request;
    assign result.reload_valid  = res_reg.reload_valid;
    assign result.tick_span_ms  = res_reg.tick_span_ms;
    assign result.period_reload = res_reg.period_reload;
    assign result.phase_out     = res_reg.phase_out;

    `ATW_ASSERT_NEXT(a_update_to_waiting, clk, rst_n, do_update,
        phase_reg == PH_WAITING && res_valid_reg && res_reg.reload_valid,
        "An update did not leave the wheel waiting with a reload.")
    `ATW_ASSERT_NEXT(a_expiry_marks_expired, clk, rst_n,
        take && op_t'(stage_item.operation) == OP_EXPIRY,
        phase_reg == PH_EXPIRED && !res_reg.reload_valid,
        "An expiry did not mark the phase expired.")
    `ATW_ASSERT_NOW(a_reload_matches_interval, clk, rst_n,
        res_valid_reg && res_reg.tick_span_ms != '0,
        (res_reg.period_reload + RELOAD_W'(1)) == (RELOAD_W'(res_reg.tick_span_ms) << 1),
        "The reload value does not match the interval.")
    `ATW_ASSERT_NOW(a_take_needs_room, clk, rst_n, take,
        stage_valid && (!res_valid_reg || result.ready),
        "An item moved into an occupied result register.")

endmodule

`default_nettype wire

@@ tb/adaptive_tick_timer_wheel_unit_tb.sv @@
`default_nettype none

module adaptive_tick_timer_wheel_unit_tb;
    import atw_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 6;
    localparam int PRINT_MAX = 40;
    localparam int PHASE_ITEMS = 170;
    localparam int RANDOM_PHASES = 8;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    atw_item_if   item_bus ();
    atw_result_if result_bus ();
    atw_cfg_if    cfg_bus ();

    adaptive_tick_timer_wheel_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    logic [MS_W-1:0]       len_cfg;
    logic [LOG2_W-1:0]     log2_cfg;
    logic                  shut_cfg;
    phase_t                wheel_phase;
    logic [MS_W-1:0]       slot_left;
    logic [SLOT_INDEX_W-1:0] slot_pos;
    logic [INTERVAL_W-1:0] last_iv;

    result_t pending_results[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_left = 0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatches = 0;
    int settings_used = 0;
    int cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    initial
    begin : watchdog
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Timeout after %0d cycles with %0d results pending.", cycles,
                         pending_results.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    function automatic logic [SLOT_INDEX_W-1:0] next_pos(input logic [SLOT_INDEX_W-1:0] pos);
        logic [LOG2_W-1:0] bits;
        logic [8:0]        mask;
        bits = (log2_cfg > MAX_SLOT_BITS_DEF) ? LOG2_W'(MAX_SLOT_BITS_DEF) : log2_cfg;
        mask = (9'd1 << bits) - 9'd1;
        return (pos + 8'd1) & mask[7:0];
    endfunction

    function automatic result_t predict_wheel(input logic [1:0] op, input logic [MS_W-1:0] ms);
        result_t               r;
        logic                  from_init;
        logic [INTERVAL_W-1:0] iv;
        logic [MS_W:0]         sum;
        r = '0;
        case (op)
            OP_UPDATE:
            begin
                if (wheel_phase == PH_INIT || wheel_phase == PH_EXPIRED)
                begin
                    from_init = (wheel_phase == PH_INIT);
                    if (!from_init)
                        slot_left = (slot_left >= MS_W'(last_iv)) ? slot_left - MS_W'(last_iv)
                                                                   : '0;
                    if (slot_left == '0)
                    begin
                        slot_left = len_cfg;
                        if (!from_init)
                            slot_pos = next_pos(slot_pos);
                    end
                    if (slot_left >= MS_W'(INTERVAL_10S))
                        iv = INTERVAL_10S;
                    else if (slot_left >= MS_W'(INTERVAL_1S))
                        iv = INTERVAL_1S;
                    else if (slot_left >= MS_W'(INTERVAL_100MS))
                        iv = INTERVAL_100MS;
                    else if (slot_left >= MS_W'(INTERVAL_10MS))
                        iv = INTERVAL_10MS;
                    else
                        iv = slot_left[INTERVAL_W-1:0];
                    last_iv = iv;
                    r.init_request = from_init;
                    r.reload_valid = 1'b1;
                    r.tick_span_ms = iv;
                    r.period_reload = (iv == '0) ? '0 : {iv, 1'b0} - 15'd1;
                    wheel_phase = PH_WAITING;
                end
            end
            OP_EXPIRY:
                wheel_phase = PH_EXPIRED;
            OP_ADD:
            begin
                if (!shut_cfg && ms != '0 && len_cfg != '0)
                begin
                    sum = {1'b0, slot_left} + {1'b0, ms};
                    if (sum >= {1'b0, len_cfg})
                    begin
                        slot_pos = next_pos(slot_pos);
                        slot_left = '0;
                    end
                    else
                        slot_left = sum[MS_W-1:0];
                end
            end
            default:
                ;
        endcase
        r.slot_index = slot_pos;
        r.remaining_ms = slot_left;
        r.phase_out = wheel_phase;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_MAX)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    initial
    begin : result_checker
        result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_bus.valid && result_bus.ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= PRINT_MAX)
                        $display("%0t: result expected none, got slot %0d remaining %0d",
                                 $time, result_bus.slot_index, result_bus.remaining_ms);
                end
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    compare_field("slot_index", 32'(want.slot_index),
                                  32'(result_bus.slot_index));
                    compare_field("remaining_ms", want.remaining_ms, result_bus.remaining_ms);
                    compare_field("init_request", 32'(want.init_request),
                                  32'(result_bus.init_request));
                    compare_field("reload_valid", 32'(want.reload_valid),
                                  32'(result_bus.reload_valid));
                    compare_field("tick_span_ms", 32'(want.tick_span_ms),
                                  32'(result_bus.tick_span_ms));
                    compare_field("period_reload", 32'(want.period_reload),
                                  32'(result_bus.period_reload));
                    compare_field("phase_out", 32'(want.phase_out), 32'(result_bus.phase_out));
                end
            end
        end
    end

    initial
    begin : result_receiver
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_left--;
            end
            else
                result_bus.ready <= rst_n && ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [MS_W-1:0] ms);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            item_bus.valid <= 1'b0;
            @(negedge clk);
        end
        item_bus.valid <= 1'b1;
        item_bus.operation <= op;
        item_bus.add_ms <= ms;
        @(posedge clk);
        while (!item_bus.ready)
            @(posedge clk);
        pending_results.push_back(predict_wheel(op, ms));
        items_sent++;
        @(negedge clk);
    endtask

    task automatic drain_pipeline();
        item_bus.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        case (idx)
            CFG_SLOT_LENGTH:     len_cfg = val;
            CFG_SLOT_COUNT_LOG2: log2_cfg = val[LOG2_W-1:0];
            CFG_WHEEL_SHUT:      shut_cfg = val[0];
            default:             ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_wheel(input logic [MS_W-1:0] len, input logic [LOG2_W-1:0] log2,
                             input logic shut);
        drain_pipeline();
        write_reg(CFG_SLOT_LENGTH, len);
        write_reg(CFG_SLOT_COUNT_LOG2, CFG_DATA_W'(log2));
        write_reg(CFG_WHEEL_SHUT, CFG_DATA_W'(shut));
        settings_used++;
    endtask

    function automatic logic [MS_W-1:0] pick_add_ms();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
            return '0;
        else if (sel < 35)
            return MS_W'($urandom_range(50, 1));
        else if (sel < 60)
            return len_cfg - slot_left + MS_W'($urandom_range(2)) - MS_W'(1);
        else if (sel < 75)
            return 32'hFFFF_FFFF - MS_W'($urandom_range(3));
        else
            return $urandom();
    endfunction

    function automatic logic [MS_W-1:0] pick_length();
        int sel;
        sel = $urandom_range(99);
        if (sel < 8)
            return '0;
        else if (sel < 20)
            return 32'd1;
        else if (sel < 50)
            return MS_W'($urandom_range(40, 2));
        else if (sel < 75)
            return MS_W'($urandom_range(25000, 900));
        else if (sel < 90)
            return $urandom();
        else
            return 32'hFFFF_FFFF;
    endfunction

    task automatic test_phase_sequence();
        send_item(OP_UNUSED, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 32'h0);
        send_item(OP_UPDATE, 32'hFFFF_FFFF);
        send_item(OP_ADD, 32'h0);
        send_item(OP_ADD, 32'hFFFF_FFFF);
        send_item(OP_EXPIRY, 32'h0);
        send_item(OP_EXPIRY, 32'hFFFF_FFFF);
        send_item(OP_UPDATE, 32'h0);
    endtask

    task automatic test_interval_ladder();
        set_wheel(32'd1111, 4'd15, 1'b0);
        repeat (4)
        begin
            send_item(OP_EXPIRY, 32'h0);
            send_item(OP_UPDATE, 32'h0);
        end
    endtask

    task automatic test_register_corners();
        set_wheel(32'd0, 4'd15, 1'b1);
        send_item(OP_ADD, 32'd7);
        send_item(OP_EXPIRY, 32'h0);
        send_item(OP_UPDATE, 32'h0);
        set_wheel(32'd0, 4'd15, 1'b0);
        send_item(OP_ADD, 32'd9);
        set_wheel(32'hFFFF_FFFF, 4'd0, 1'b0);
        send_item(OP_EXPIRY, 32'h0);
        send_item(OP_UPDATE, 32'h0);
        send_item(OP_ADD, 32'hFFFF_FFFF);
    endtask

    task automatic test_random_traffic(input int count, input int idle_pct, input int stall);
        int sent;
        int sel;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        while (sent < count)
        begin
            sel = $urandom_range(99);
            if (sel < 35)
            begin
                send_item(OP_EXPIRY, $urandom());
                send_item(OP_UPDATE, $urandom());
                sent += 2;
            end
            else
            begin
                if (sel < 60)
                    send_item(OP_ADD, pick_add_ms());
                else if (sel < 72)
                    send_item(OP_UPDATE, $urandom());
                else if (sel < 84)
                    send_item(OP_EXPIRY, $urandom());
                else if (sel < 92)
                    send_item(OP_UNUSED, $urandom());
                else
                    send_item(OP_ADD, $urandom());
                sent++;
            end
        end
    endtask

    task automatic test_result_backpressure();
        set_wheel(32'd25, 4'd4, 1'b0);
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = HOLD_OFF_CYCLES;
        test_random_traffic(40, 0, 0);
    endtask

    initial
    begin : main_sequence
        logic [LOG2_W-1:0] log2;
        int                idle_pct;
        int                stall;
        item_bus.valid = 1'b0;
        item_bus.operation = OP_UPDATE;
        item_bus.add_ms = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_SLOT_LENGTH;
        cfg_bus.data = '0;
        rst_n = 1'b0;
        len_cfg = SLOT_LENGTH_RESET;
        log2_cfg = SLOT_COUNT_LOG2_RESET;
        shut_cfg = 1'b0;
        wheel_phase = PH_INIT;
        slot_left = '0;
        slot_pos = '0;
        last_iv = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_phase_sequence();
        test_interval_ladder();
        test_register_corners();

        for (int k = 0; k < RANDOM_PHASES; k++)
        begin
            if (k == 0)
                set_wheel(32'd10, 4'd8, 1'b0);
            else
            begin
                log2 = ($urandom_range(99) < 70) ? LOG2_W'($urandom_range(8))
                                                 : LOG2_W'($urandom_range(15, 9));
                set_wheel(pick_length(), log2, $urandom_range(99) < 20);
            end
            case (k % 4)
                0:       begin idle_pct = 0;  stall = 0;  end
                1:       begin idle_pct = 62; stall = 0;  end
                2:       begin idle_pct = 0;  stall = 62; end
                default: begin idle_pct = 24; stall = 24; end
            endcase
            test_random_traffic(PHASE_ITEMS, idle_pct, stall);
        end

        test_result_backpressure();
        drain_pipeline();

        $display("Sent %0d items and checked %0d results over %0d wheel settings.",
                 items_sent, results_checked, settings_used);
        $display("Traffic mixed input gaps, output stalls and one long result hold-off.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+hdl
hdl/atw_pkg.sv
hdl/atw_item_if.sv
hdl/atw_result_if.sv
hdl/atw_cfg_if.sv
hdl/atw_cfg_regs.sv
hdl/atw_in_stage.sv
hdl/atw_core.sv
hdl/adaptive_tick_timer_wheel_unit.sv
tb/adaptive_tick_timer_wheel_unit_tb.sv
